// ----- sv/circular_list_with_cursor_assert.svh -----
// assertion macros for the circular list with cursor
`ifndef CIRCULAR_LIST_WITH_CURSOR_ASSERT_SVH
`define CIRCULAR_LIST_WITH_CURSOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CLL_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("circular list check failed");

// next-cycle implication, checked out of reset
`define CLL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("circular list sequencing check failed");

`endif

// ----- sv/cll_pkg.sv -----
// shared codes and transaction types of the circular list with cursor
package cll_pkg;

   localparam logic [2:0] ACT_INS_AFTER  = 3'd0;
   localparam logic [2:0] ACT_INS_BEFORE = 3'd1;
   localparam logic [2:0] ACT_REMOVE     = 3'd2;
   localparam logic [2:0] ACT_NEXT       = 3'd3;
   localparam logic [2:0] ACT_PREV       = 3'd4;
   localparam logic [2:0] ACT_CLEAR      = 3'd5;
   localparam logic [2:0] ACT_READ       = 3'd6;

   localparam logic [1:0] STS_OK           = 2'd0;
   localparam logic [1:0] STS_REMOVE_EMPTY = 2'd1;
   localparam logic [1:0] STS_FULL         = 2'd2;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] item_value;
   } cll_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        list_empty;
      logic [8:0]  list_length;
      logic [31:0] cursor_value;
   } cll_rsp_type;

   typedef struct packed {
      logic idle;
      logic load;
   } cll_ctl_type;

endpackage

// ----- sv/cll_seq.sv -----
// sequencer, slot memories and list state of the circular list
module cll_seq #(
   parameter int DATA_WIDTH = 32,
   parameter int CAPACITY   = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  cll_pkg::cll_req_type req,
   input  logic                 out_free,
   output cll_pkg::cll_ctl_type ctl,
   output cll_pkg::cll_rsp_type rsp
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_START = 6'b000010,
      ST_LINK  = 6'b000100,
      ST_FIX   = 6'b001000,
      ST_VAL   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         top_ff, top_in;
   logic [CW-1:0]         mark_ff, mark_in;
   logic [AW-1:0]         cursor_ff, cursor_in;
   logic [DATA_WIDTH-1:0] cur_val_ff, cur_val_in;
   logic [2:0]            act_ff, act_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [1:0]            status_ff, status_in;
   logic [AW-1:0]         slot_ff, slot_in;
   logic [AW-1:0]         nb_ff, nb_in;

   // slot memories
   logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];
   logic [AW-1:0]         next_mem [CAPACITY];
   logic [AW-1:0]         prev_mem [CAPACITY];
   logic [AW-1:0]         free_mem [CAPACITY];

   logic                  v_we, n_we, p_we, f_we;
   logic [AW-1:0]         v_wa, n_wa, p_wa, f_wa;
   logic [AW-1:0]         v_ra, n_ra, p_ra, f_ra;
   logic [DATA_WIDTH-1:0] v_wd;
   logic [AW-1:0]         n_wd, p_wd, f_wd;
   logic [DATA_WIDTH-1:0] v_rd_ff;
   logic [AW-1:0]         n_rd_ff, p_rd_ff, f_rd_ff;

   logic [DATA_WIDTH+31:0] val_ext;
   logic [DATA_WIDTH+31:0] cur_ext;
   logic [CW+8:0]          len_ext;
   logic [CW-1:0]          top_dec;
   logic [AW-1:0]          new_slot;
   logic                   is_after;

   assign val_ext  = {{DATA_WIDTH{1'b0}}, req.item_value};
   assign top_dec  = top_ff - CW'(1);
   assign new_slot = (top_ff != '0) ? f_rd_ff : mark_ff[AW-1:0];
   assign is_after = (act_ff == cll_pkg::ACT_INS_AFTER);

   always_ff @(posedge clock) begin
      if (v_we) val_mem[v_wa] <= v_wd;
      v_rd_ff <= val_mem[v_ra];
   end

   always_ff @(posedge clock) begin
      if (n_we) next_mem[n_wa] <= n_wd;
      n_rd_ff <= next_mem[n_ra];
   end

   always_ff @(posedge clock) begin
      if (p_we) prev_mem[p_wa] <= p_wd;
      p_rd_ff <= prev_mem[p_ra];
   end

   always_ff @(posedge clock) begin
      if (f_we) free_mem[f_wa] <= f_wd;
      f_rd_ff <= free_mem[f_ra];
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      top_in     = top_ff;
      mark_in    = mark_ff;
      cursor_in  = cursor_ff;
      cur_val_in = cur_val_ff;
      act_in     = act_ff;
      val_in     = val_ff;
      status_in  = status_ff;
      slot_in    = slot_ff;
      nb_in      = nb_ff;
      v_we = 1'b0; v_wa = new_slot; v_wd = val_ff; v_ra = n_rd_ff;
      n_we = 1'b0; n_wa = new_slot; n_wd = n_rd_ff; n_ra = cursor_ff;
      p_we = 1'b0; p_wa = new_slot; p_wd = p_rd_ff; p_ra = cursor_ff;
      f_we = 1'b0; f_wa = top_ff[AW-1:0]; f_wd = cursor_ff; f_ra = top_dec[AW-1:0];
      ctl.idle = 1'b0;
      ctl.load = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            ctl.idle = 1'b1;
            if (req_valid) begin
               act_in    = req.action;
               val_in    = val_ext[DATA_WIDTH-1:0];
               status_in = cll_pkg::STS_OK;
               state_in  = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_DONE;
            unique case (act_ff) inside
               cll_pkg::ACT_INS_AFTER, cll_pkg::ACT_INS_BEFORE: begin
                  if (count_ff == CW'(CAPACITY)) status_in = cll_pkg::STS_FULL;
                  else state_in = ST_LINK;
               end
               cll_pkg::ACT_REMOVE: begin
                  if (count_ff == '0) status_in = cll_pkg::STS_REMOVE_EMPTY;
                  else state_in = ST_LINK;
               end
               cll_pkg::ACT_NEXT, cll_pkg::ACT_PREV: begin
                  if (count_ff != '0) state_in = ST_LINK;
               end
               cll_pkg::ACT_CLEAR: begin
                  count_in  = '0;
                  top_in    = '0;
                  mark_in   = '0;
                  cursor_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_LINK: begin
            unique case (act_ff) inside
               cll_pkg::ACT_INS_AFTER, cll_pkg::ACT_INS_BEFORE: begin
                  if (top_ff != '0) top_in = top_dec;
                  else mark_in = mark_ff + CW'(1);
                  v_we = 1'b1;
                  n_we = 1'b1;
                  p_we = 1'b1;
                  if (count_ff == '0) begin
                     // first item links to itself
                     n_wd       = new_slot;
                     p_wd       = new_slot;
                     cursor_in  = new_slot;
                     count_in   = count_ff + CW'(1);
                     cur_val_in = val_ff;
                     state_in   = ST_DONE;
                  end else begin
                     n_wd     = is_after ? n_rd_ff : cursor_ff;
                     p_wd     = is_after ? cursor_ff : p_rd_ff;
                     nb_in    = is_after ? n_rd_ff : p_rd_ff;
                     slot_in  = new_slot;
                     state_in = ST_FIX;
                  end
               end
               cll_pkg::ACT_REMOVE: begin
                  f_we     = 1'b1;
                  top_in   = top_ff + CW'(1);
                  count_in = count_ff - CW'(1);
                  if (count_ff == CW'(1)) begin
                     cursor_in = '0;
                     state_in  = ST_DONE;
                  end else begin
                     // unlink: prev.next = next, next.prev = prev
                     n_we      = 1'b1;
                     n_wa      = p_rd_ff;
                     n_wd      = n_rd_ff;
                     p_we      = 1'b1;
                     p_wa      = n_rd_ff;
                     p_wd      = p_rd_ff;
                     cursor_in = n_rd_ff;
                     v_ra      = n_rd_ff;
                     state_in  = ST_VAL;
                  end
               end
               cll_pkg::ACT_PREV: begin
                  cursor_in = p_rd_ff;
                  v_ra      = p_rd_ff;
                  state_in  = ST_VAL;
               end
               default: begin
                  cursor_in = n_rd_ff;
                  v_ra      = n_rd_ff;
                  state_in  = ST_VAL;
               end
            endcase
         end
         ST_FIX: begin
            // point the neighbors at the new slot
            n_we       = 1'b1;
            n_wa       = is_after ? cursor_ff : nb_ff;
            n_wd       = slot_ff;
            p_we       = 1'b1;
            p_wa       = is_after ? nb_ff : cursor_ff;
            p_wd       = slot_ff;
            cursor_in  = slot_ff;
            count_in   = count_ff + CW'(1);
            cur_val_in = val_ff;
            state_in   = ST_DONE;
         end
         ST_VAL: begin
            cur_val_in = v_rd_ff;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               ctl.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         top_ff    <= '0;
         mark_ff   <= '0;
         cursor_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         top_ff    <= top_in;
         mark_ff   <= mark_in;
         cursor_ff <= cursor_in;
      end
      cur_val_ff <= cur_val_in;
      act_ff     <= act_in;
      val_ff     <= val_in;
      status_ff  <= status_in;
      slot_ff    <= slot_in;
      nb_ff      <= nb_in;
   end

   assign cur_ext = {32'b0, cur_val_ff};
   assign len_ext = {9'b0, count_ff};

   assign rsp.cursor_value = (count_ff != '0) ? cur_ext[31:0] : 32'b0;
   assign rsp.list_length  = len_ext[8:0];
   assign rsp.list_empty   = (count_ff == '0);
   assign rsp.status       = status_ff;

endmodule

// ----- sv/circular_list_with_cursor.sv -----
// top level of the circular list with cursor: stream ports and result register
//
// a bounded circular doubly linked list of up to CAPACITY values with a cursor.
// each request transaction carries an action in req_tuser and a value in
// req_tdata; each one returns exactly one response transaction with the cursor
// value, the length, an empty flag and a status. a request runs start, done
// (read, clear, failed insert or remove, step on an empty list); start, link,
// done (insert into an empty list, remove of the last item); start, link, fix,
// done (insert into a non-empty list); or start, link, val, done (step next or
// previous, remove with items left). done waits for a free result register and
// loads the response there; the sequencer then returns to idle before taking
// the next request. the link memories each have one registered read and one
// write per cycle: a registered read of the cursor neighbors, then the link
// writes, then for a step or remove a value read for the new cursor. req_tready
// is high only while the sequencer is idle; a finished response sits in its own
// output register, so the next request is taken while the previous response
// still waits for rsp_tready. no clearing pass is needed after reset.
`include "circular_list_with_cursor_assert.svh"

module circular_list_with_cursor #(
   parameter int DATA_WIDTH = 32,
   parameter int CAPACITY   = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // item_value [31:0]
   input  logic [2:0]  req_tuser,   // action [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // cursor_value [31:0], list_length [40:32],
                                    // list_empty [41], status [43:42], zero [47:44]
);

   cll_pkg::cll_req_type req;
   cll_pkg::cll_rsp_type rsp;
   cll_pkg::cll_ctl_type ctl;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        out_free;

   assign req.action     = req_tuser;
   assign req.item_value = req_tdata;

   // the result register can take a new response when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;

   cll_seq #(
      .DATA_WIDTH (DATA_WIDTH),
      .CAPACITY   (CAPACITY)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req       (req),
      .out_free  (out_free),
      .ctl       (ctl),
      .rsp       (rsp)
   );

   assign req_tready = ctl.idle;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctl.load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0, rsp.status, rsp.list_empty, rsp.list_length,
                         rsp.cursor_value};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a taken request keeps the sequencer busy for at least the next cycle
   `CLL_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)

   // a finished response shows up on the result port in the next cycle
   `CLL_ASSERT_NEXT(a_load_shows, ctl.load, rsp_tvalid)

   // a refused insert reports a full list
   `CLL_ASSERT_IMPLY(a_full_length,
      rsp_tvalid && (rsp_tdata[43:42] == cll_pkg::STS_FULL),
      rsp_tdata[40:32] == 9'(CAPACITY))

   // a refused remove reports an empty list
   `CLL_ASSERT_IMPLY(a_empty_flag,
      rsp_tvalid && (rsp_tdata[43:42] == cll_pkg::STS_REMOVE_EMPTY),
      rsp_tdata[41])

endmodule
